[rtl/core/cspf_pkg.sv]
// ----------------------------------------------------------------------------
// cspf_pkg
// Types and constants shared by the color sensor frequency measurement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cspf_pkg;

    localparam int RATE_W = 17;
    localparam int CHAN_W = 2;
    localparam int CAPT_W = 8;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd125000;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_EDGE  = 1'b1;

    // filter channels, also the dominant color codes
    localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CHAN_W-1:0] CH_CLEAR = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] channel;
        logic [CAPT_W-1:0] timer_count;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] measured_channel;
        logic [RATE_W-1:0] frequency;
        logic              color_valid;
        logic [CHAN_W-1:0] dominant_color;
    } t_out_item;

endpackage

[rtl/core/cspf_front.sv]
// ----------------------------------------------------------------------------
// cspf_front
// Accepts start and edge items, tracks the edge count and start time, and
// queues a period job at the edge item that follows the one setting the start time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cspf_front #(
    parameter int TIMER_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cspf_pkg::t_in_item                  i_in_item,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [cspf_pkg::CHAN_W+TIMER_BITS-1:0] o_q_data
);

    localparam logic [1:0] EC_NONE = 2'd0;
    localparam logic [1:0] EC_ONE  = 2'd1;
    localparam logic [1:0] EC_DONE = 2'd2;

    logic [1:0]                    r_edge_count, n_edge_count;
    logic [cspf_pkg::CAPT_W-1:0]   r_start, n_start;
    logic [cspf_pkg::CHAN_W-1:0]   r_chan, n_chan;
    logic                          accept;
    logic [TIMER_BITS-1:0]         period;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    // difference wraps modulo 2^TIMER_BITS
    assign period     = TIMER_BITS'(i_in_item.timer_count) - TIMER_BITS'(r_start);
    assign o_q_data   = {r_chan, period};

    always_comb begin
        n_edge_count = r_edge_count;
        n_start      = r_start;
        n_chan       = r_chan;
        o_q_push     = 1'b0;
        if (accept) begin
            if (i_in_item.kind == cspf_pkg::KIND_START) begin
                n_chan       = i_in_item.channel;
                n_edge_count = EC_NONE;
            end else if (r_edge_count == EC_NONE) begin
                n_start      = i_in_item.timer_count;
                n_edge_count = EC_ONE;
            end else if (r_edge_count == EC_ONE) begin
                n_edge_count = EC_DONE;
                o_q_push     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= EC_NONE;
            r_start      <= '0;
            r_chan       <= cspf_pkg::CH_RED;
        end else begin
            r_edge_count <= n_edge_count;
            r_start      <= n_start;
            r_chan       <= n_chan;
        end
    end

`ifndef NO_ASSERTIONS
    a_edge_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count != 2'd3)
        else $error("edge count out of range");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full)
        else $error("job pushed into full queue");

    a_push_ends_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> r_edge_count == EC_DONE)
        else $error("edge count not closed after job");
`endif

endmodule

[rtl/core/cspf_queue.sv]
// ----------------------------------------------------------------------------
// cspf_queue
// Two-entry job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cspf_queue #(
    parameter int W = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count, n_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/core/cspf_back.sv]
// ----------------------------------------------------------------------------
// cspf_back
// Serial restoring divider for rate / period, red and green storage,
// dominant color decision and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cspf_back #(
    parameter int TIMER_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cspf_pkg::RATE_W-1:0]            i_cfg_wdata,
    input  logic                                   i_job_empty,
    input  logic [cspf_pkg::CHAN_W+TIMER_BITS-1:0] i_job_data,
    output logic                                   o_job_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output cspf_pkg::t_out_item                    o_out_item
);

    localparam int RW    = cspf_pkg::RATE_W;
    localparam int CNT_W = $clog2(RW + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                  r_state;
    logic [CNT_W-1:0]            r_cnt;
    logic [TIMER_BITS-1:0]       r_rem;
    logic [RW-1:0]               r_quo;
    logic [TIMER_BITS-1:0]       r_per;
    logic [cspf_pkg::CHAN_W-1:0] r_chan;
    logic [RW-1:0]               r_rate;
    logic [RW-1:0]               r_red, r_green;
    logic                        r_out_valid;
    cspf_pkg::t_out_item         r_out;

    logic [TIMER_BITS:0]         shifted;
    logic [TIMER_BITS+1:0]       trial;
    logic                        ge;
    logic [RW-1:0]               freq;
    logic [cspf_pkg::CHAN_W-1:0] dom;
    logic                        out_free;
    logic                        fin_load;
    cspf_pkg::t_out_item         n_out;

    // one quotient bit per cycle, dividend shifts out of the top of r_quo
    assign shifted = {r_rem, r_quo[RW-1]};
    assign trial   = {1'b0, shifted} - (TIMER_BITS+2)'(r_per);
    assign ge      = !trial[TIMER_BITS+1];

    assign freq     = (r_per == '0) ? '0 : r_quo;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fin_load = (r_state == S_FIN) && out_free;
    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;

    always_comb begin
        if (r_red >= r_green && r_red >= freq) begin
            dom = cspf_pkg::CH_RED;
        end else if (r_green >= freq) begin
            dom = cspf_pkg::CH_GREEN;
        end else begin
            dom = cspf_pkg::CH_BLUE;
        end
        n_out.measured_channel = r_chan;
        n_out.frequency        = freq;
        n_out.color_valid      = r_chan == cspf_pkg::CH_BLUE;
        n_out.dominant_color   = (r_chan == cspf_pkg::CH_BLUE) ? dom : cspf_pkg::CH_RED;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_per  <= i_job_data[TIMER_BITS-1:0];
            r_chan <= i_job_data[cspf_pkg::CHAN_W+TIMER_BITS-1:TIMER_BITS];
            r_rem  <= '0;
            r_quo  <= r_rate;
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? trial[TIMER_BITS-1:0] : shifted[TIMER_BITS-1:0];
            r_quo <= {r_quo[RW-2:0], ge};
        end
        if (fin_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rate      <= cspf_pkg::RATE_RESET;
            r_red       <= '0;
            r_green     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_cnt   <= CNT_W'(RW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (fin_load) begin
                if (r_chan == cspf_pkg::CH_RED) begin
                    r_red <= freq;
                end else if (r_chan == cspf_pkg::CH_GREEN) begin
                    r_green <= freq;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_div_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt != '0)
        else $error("divider running with zero count");

    a_color_only_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.color_valid) |-> r_out.measured_channel == cspf_pkg::CH_BLUE)
        else $error("color decision on non-blue item");

    a_dom_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.dominant_color != cspf_pkg::CH_CLEAR)
        else $error("invalid dominant color code");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load |=> r_state == S_IDLE && r_out_valid)
        else $error("finish did not return to idle with result");
`endif

endmodule

[rtl/core/color_sensor_period_to_frequency.sv]
// ----------------------------------------------------------------------------
// color_sensor_period_to_frequency
// Light-to-frequency sensor measurement: period to frequency per channel.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_item): a start item picks the
// filter channel and clears the edge count; edge items carry timer captures.
// The edge after the one that set the start time queues a job with the wrapped period.
// Output channel (o_out_valid / i_out_stall / o_out_item): one item per
// finished measurement, frequency = count_rate / period (0 for period 0),
// and on blue the dominant color among red, green and blue.
// Config: i_cfg_we / i_cfg_wdata write count_rate (reset 125000).
// Path from the queuing edge to o_out_valid: the job passes through the
// two-entry job queue, the bit-serial divider (one quotient bit per cycle)
// and the finish step that loads the output register.
// Flow: the divider finishes one job before it pops the next. Items are
// taken one per cycle while the job queue has room; o_in_stall is high when
// it holds two jobs. A stalled output holds its item and the divider
// waits in its finish step; the front keeps accepting until the queue fills.
// Reset: edge count, start time, channel (red), stored red/green frequencies
// clear, count_rate returns to 125000, output valid drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_sensor_period_to_frequency #(
    parameter int TIMER_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cspf_pkg::RATE_W-1:0]     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cspf_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cspf_pkg::t_out_item             o_out_item
);

    localparam int JOB_W = cspf_pkg::CHAN_W + TIMER_BITS;

    logic             q_push, q_pop, q_full, q_empty;
    logic [JOB_W-1:0] q_wdata, q_rdata;

    cspf_front #(
        .TIMER_BITS(TIMER_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    cspf_queue #(
        .W(JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    cspf_back #(
        .TIMER_BITS(TIMER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_empty (q_empty),
        .i_job_data  (q_rdata),
        .o_job_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks color_sensor_period_to_frequency against an in-bench prediction of
// the measurement sequence: start items, timer-capture edge items, the
// wrapped period, the count_rate division and the dominant color on blue.
// Directed cases come first, then random phases at several count_rate values,
// with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_PCT      = 17;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [cspf_pkg::RATE_W-1:0] cfg_wdata;
    logic                        in_valid;
    logic                        in_stall;
    cspf_pkg::t_in_item          in_item;
    logic                        out_valid;
    logic                        out_stall;
    cspf_pkg::t_out_item         out_item;

    color_sensor_period_to_frequency i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted measurement state
    logic [cspf_pkg::RATE_W-1:0] rate_now;
    logic [1:0]                  edges_seen;
    logic [cspf_pkg::CAPT_W-1:0] first_capture;
    logic [cspf_pkg::CHAN_W-1:0] cur_chan;
    logic [cspf_pkg::RATE_W-1:0] red_freq;
    logic [cspf_pkg::RATE_W-1:0] green_freq;

    cspf_pkg::t_out_item awaited_results[$];

    int  errors        = 0;
    int  items_counted = 0;
    int  results_seen  = 0;
    int  rate_writes   = 0;
    int  hold_left     = 0;
    bit  no_idle       = 1'b0;

    function automatic logic [cspf_pkg::RATE_W-1:0] rate_over_period(
        input logic [cspf_pkg::RATE_W-1:0] rate,
        input logic [cspf_pkg::CAPT_W-1:0] period);
        if (period == '0) return '0;
        return rate / period;
    endfunction

    function automatic logic [cspf_pkg::CHAN_W-1:0] strongest_color(
        input logic [cspf_pkg::RATE_W-1:0] r,
        input logic [cspf_pkg::RATE_W-1:0] g,
        input logic [cspf_pkg::RATE_W-1:0] b);
        if (r >= g && r >= b) return cspf_pkg::CH_RED;
        if (g >= b) return cspf_pkg::CH_GREEN;
        return cspf_pkg::CH_BLUE;
    endfunction

    task automatic clear_measurements();
        rate_now      = cspf_pkg::RATE_RESET;
        edges_seen    = '0;
        first_capture = '0;
        cur_chan      = cspf_pkg::CH_RED;
        red_freq      = '0;
        green_freq    = '0;
    endtask

    task automatic track_item(input cspf_pkg::t_in_item it);
        cspf_pkg::t_out_item         res;
        logic [cspf_pkg::CAPT_W-1:0] period;
        logic [cspf_pkg::RATE_W-1:0] freq;
        if (it.kind == cspf_pkg::KIND_START) begin
            cur_chan   = it.channel;
            edges_seen = 2'd0;
        end else if (edges_seen == 2'd0) begin
            first_capture = it.timer_count;
            edges_seen    = 2'd1;
        end else if (edges_seen == 2'd1) begin
            edges_seen = 2'd2;
            period = it.timer_count - first_capture;  // wraps at 8 bits
            freq   = rate_over_period(rate_now, period);
            res    = '0;
            res.measured_channel = cur_chan;
            res.frequency        = freq;
            case (cur_chan)
                cspf_pkg::CH_RED: begin
                    red_freq = freq;
                end
                cspf_pkg::CH_GREEN: begin
                    green_freq = freq;
                end
                cspf_pkg::CH_BLUE: begin
                    res.color_valid    = 1'b1;
                    res.dominant_color = strongest_color(red_freq, green_freq, freq);
                end
                default: begin
                end
            endcase
            awaited_results.push_back(res);
        end
        // later edges are dropped by the block
    endtask

    function automatic cspf_pkg::t_in_item start_item(input logic [cspf_pkg::CHAN_W-1:0] ch);
        cspf_pkg::t_in_item it;
        it.kind        = cspf_pkg::KIND_START;
        it.channel     = ch;
        it.timer_count = cspf_pkg::CAPT_W'($urandom);
        return it;
    endfunction

    function automatic cspf_pkg::t_in_item edge_item(input logic [cspf_pkg::CAPT_W-1:0] t);
        cspf_pkg::t_in_item it;
        it.kind        = cspf_pkg::KIND_EDGE;
        it.channel     = cspf_pkg::CHAN_W'($urandom);
        it.timer_count = t;
        return it;
    endfunction

    // valid is only changed before waiting on an edge, never right after acceptance
    task automatic send_item(input cspf_pkg::t_in_item it);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_counted++;
        track_item(it);
    endtask

    task automatic measure(input logic [cspf_pkg::CHAN_W-1:0] ch,
                           input logic [cspf_pkg::CAPT_W-1:0] t0,
                           input logic [cspf_pkg::CAPT_W-1:0] t1);
        send_item(start_item(ch));
        send_item(edge_item(t0));
        send_item(edge_item(t1));
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    task automatic settle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [cspf_pkg::RATE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        rate_now = value;
        rate_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result side: random stall, long hold-off on request, in-order compare
    initial begin : result_side
        cspf_pkg::t_out_item want;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected item, expected none, got %h", $time, out_item);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("measured_channel", 32'(want.measured_channel),
                                32'(out_item.measured_channel));
                    check_field("frequency", 32'(want.frequency), 32'(out_item.frequency));
                    check_field("color_valid", 32'(want.color_valid),
                                32'(out_item.color_valid));
                    check_field("dominant_color", 32'(want.dominant_color),
                                32'(out_item.dominant_color));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // edges with no start measure red; a start ignores its timer field
    task automatic test_power_on_red();
        send_item(edge_item(8'd10));
        send_item(edge_item(8'd20));
        send_item(edge_item(8'd30));
        send_item(start_item(cspf_pkg::CH_CLEAR));
        send_item(edge_item(8'd255));
        send_item(edge_item(8'd0));
    endtask

    task automatic test_special_cases();
        measure(cspf_pkg::CH_GREEN, 8'd0, 8'd0);      // zero period
        measure(cspf_pkg::CH_BLUE, 8'd7, 8'd7);       // all low but red: red wins
        measure(cspf_pkg::CH_RED, 8'd0, 8'd0);
        measure(cspf_pkg::CH_GREEN, 8'd100, 8'd110);
        measure(cspf_pkg::CH_BLUE, 8'd200, 8'd210);   // green ties blue: green wins
        measure(cspf_pkg::CH_BLUE, 8'd0, 8'd5);       // blue above both
    endtask

    task automatic test_rate_extremes();
        settle();
        write_rate(17'd1);
        measure(cspf_pkg::CH_RED, 8'd40, 8'd41);
        measure(cspf_pkg::CH_BLUE, 8'd3, 8'd5);
        settle();
        write_rate(17'h1FFFF);
        measure(cspf_pkg::CH_RED, 8'd255, 8'd0);
        measure(cspf_pkg::CH_GREEN, 8'd1, 8'd0);
        measure(cspf_pkg::CH_BLUE, 8'd128, 8'd129);   // red ties blue: red wins
    endtask

    task automatic test_input_backpressure();
        settle();
        write_rate(cspf_pkg::RATE_RESET);
        hold_left = 400;
        repeat (10) begin
            measure(cspf_pkg::CHAN_W'($urandom), cspf_pkg::CAPT_W'($urandom),
                    cspf_pkg::CAPT_W'($urandom));
        end
        wait_results_done();
    endtask

    task automatic run_random_phase(input logic [cspf_pkg::RATE_W-1:0] rate, input int goal);
        int                          target;
        int                          pick;
        logic [cspf_pkg::CAPT_W-1:0] t0;
        logic [cspf_pkg::CAPT_W-1:0] t1;
        settle();
        write_rate(rate);
        target = items_counted + goal;
        while (items_counted < target) begin
            pick = $urandom_range(99);
            t0   = cspf_pkg::CAPT_W'($urandom);
            t1   = ($urandom_range(99) < 30) ? t0 + cspf_pkg::CAPT_W'($urandom_range(3))
                                             : cspf_pkg::CAPT_W'($urandom);
            if (pick < 70) begin
                measure(cspf_pkg::CHAN_W'($urandom), t0, t1);
                if ($urandom_range(3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(edge_item(cspf_pkg::CAPT_W'($urandom)));
                    end
                end
            end else if (pick < 85) begin
                // measurement cut short by a new start
                send_item(start_item(cspf_pkg::CHAN_W'($urandom)));
                if ($urandom_range(1)) send_item(edge_item(t0));
            end else if ($urandom_range(1) != 0) begin
                send_item(edge_item(cspf_pkg::CAPT_W'($urandom)));
            end else begin
                send_item(start_item(cspf_pkg::CHAN_W'($urandom)));
            end
        end
    endtask

    task automatic test_random_phases();
        run_random_phase(cspf_pkg::RATE_W'($urandom_range(1, 131071)), 280);
        no_idle = 1'b1;
        run_random_phase(cspf_pkg::RATE_W'($urandom_range(1, 131071)), 280);
        no_idle = 1'b0;
        run_random_phase(cspf_pkg::RATE_W'($urandom_range(1, 300)), 280);
        run_random_phase(17'h1FFFF, 280);
        run_random_phase(cspf_pkg::RATE_W'($urandom_range(1, 131071)), 280);
        run_random_phase(cspf_pkg::RATE_W'($urandom_range(1000, 131071)), 280);
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        clear_measurements();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_red();
        test_special_cases();
        test_rate_extremes();
        test_input_backpressure();
        test_random_phases();

        wait_results_done();
        repeat (40) @(posedge clk);
        $display("Covered %0d input items and %0d measurement results at %0d rate settings,",
                 items_counted, results_seen, rate_writes + 1);
        $display("including zero periods, wraparound, color ties and a long output hold-off.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
